>>> src/utf8_to_utf16_stream_decoder_top_macros.svh
// assertion macros for the utf-8 to utf-16 decoder
// used by the rtl files that carry concurrent assertions
`ifndef UTF8_TO_UTF16_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define U8U16_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define U8U16_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define U8U16_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define U8U16_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/u8u16_pkg.sv
// shared types, constants and helpers of the utf-8 to utf-16 decoder
// no dependencies
`default_nettype none
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT = 16'hFFFD;
    localparam logic [5:0]  SUR_HI_TAG = 6'b110110;   // 0xD800 >> 10
    localparam logic [5:0]  SUR_LO_TAG = 6'b110111;   // 0xDC00 >> 10
    localparam logic [20:0] CP_BASE = 21'h10000;
    localparam logic [20:0] CP_MAX = 21'h10FFFF;
    localparam logic [7:0]  LEAD2_LO = 8'hC2;
    localparam logic [7:0]  LEAD2_HI = 8'hDF;
    localparam logic [7:0]  LEAD3_LO = 8'hE0;
    localparam logic [7:0]  LEAD3_SUR = 8'hED;
    localparam logic [7:0]  LEAD3_HI = 8'hEF;
    localparam logic [7:0]  LEAD4_LO = 8'hF0;
    localparam logic [7:0]  LEAD4_HI = 8'hF4;
    localparam logic [7:0]  MIN_E0 = 8'hA0;
    localparam logic [7:0]  MAX_ED = 8'h9F;
    localparam logic [7:0]  MIN_F0 = 8'h90;
    localparam logic [7:0]  MAX_F4 = 8'h8F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOW
    } state_t;

    // outcome of one decode step at the head of the byte window
    typedef struct packed {
        logic        stop;     // incomplete sequence at the head, wait for bytes
        logic [2:0]  adv;      // bytes consumed
        logic [2:0]  rest;     // bytes left after this step
        logic        rep;
        logic        pair;
        logic        more;     // another unit follows from the remaining bytes
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
    } step_t;

    // sequence length called for by a lead byte, 0 when not a multi-byte lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= LEAD2_LO && b <= LEAD2_HI)
            len = 3'd2;
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
            len = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
            len = 3'd4;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage
`default_nettype wire

>>> src/u8u16_byte_if.sv
// input channel of the decoder: one utf-8 byte per transaction
// no dependencies
`default_nettype none
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

>>> src/u8u16_unit_if.sv
// output channel of the decoder: one utf-16 code unit per transaction
// no dependencies
`default_nettype none
interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_replacement;
    logic        last;

    modport source (output valid, output code_unit, output is_replacement, output last,
                    input ready);
    modport sink (input valid, input code_unit, input is_replacement, input last,
                  output ready);
endinterface
`default_nettype wire

>>> src/u8u16_step.sv
// shared decode unit: one decode step on the head of the byte window
// depends on u8u16_pkg
`default_nettype none
module u8u16_step (
    input  wire logic [3:0][7:0] win,
    input  wire logic [2:0]      count,
    output u8u16_pkg::step_t     res
);

    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  len;
    logic [2:0]  next_len;
    logic [7:0]  next_byte;
    logic [20:0] cp;
    logic [20:0] v;
    logic        bad;

    assign b0 = win[0];
    assign b1 = win[1];
    assign b2 = win[2];
    assign b3 = win[3];
    assign len = u8u16_pkg::lead_len(b0);

    always_comb
    begin
        bad = 1'b0;
        cp = 21'd0;
        res = '0;
        res.adv = 3'd1;
        if (b0[7] == 1'b0)
        begin
            cp = {13'd0, b0};
        end
        else if (len == 3'd0)
        begin
            bad = 1'b1;
        end
        else if (len > count)
        begin
            res.stop = 1'b1;
        end
        else if (!u8u16_pkg::is_cont(b1))
        begin
            bad = 1'b1;
        end
        else if (len == 3'd2)
        begin
            cp = {10'd0, b0[4:0], b1[5:0]};
            res.adv = 3'd2;
        end
        else if (!u8u16_pkg::is_cont(b2)
                 || (len == 3'd3 && b0 == u8u16_pkg::LEAD3_LO && b1 < u8u16_pkg::MIN_E0)
                 || (len == 3'd3 && b0 == u8u16_pkg::LEAD3_SUR && b1 > u8u16_pkg::MAX_ED))
        begin
            bad = 1'b1;
        end
        else if (len == 3'd3)
        begin
            cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            res.adv = 3'd3;
        end
        else if (!u8u16_pkg::is_cont(b3)
                 || (b0 == u8u16_pkg::LEAD4_LO && b1 < u8u16_pkg::MIN_F0)
                 || (b0 == u8u16_pkg::LEAD4_HI && b1 > u8u16_pkg::MAX_F4))
        begin
            bad = 1'b1;
        end
        else
        begin
            cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            if (cp > u8u16_pkg::CP_MAX)
                bad = 1'b1;
            else
                res.adv = 3'd4;
        end

        v = cp - u8u16_pkg::CP_BASE;
        res.rep = bad;
        res.pair = !bad && !res.stop && (cp[20:16] != 5'd0);
        if (bad)
            res.unit_hi = u8u16_pkg::REPL_UNIT;
        else if (res.pair)
            res.unit_hi = {u8u16_pkg::SUR_HI_TAG, v[19:10]};
        else
            res.unit_hi = cp[15:0];
        res.unit_lo = {u8u16_pkg::SUR_LO_TAG, v[9:0]};
        res.rest = count - res.adv;

        // a following byte gives a unit unless it is a lead still waiting for bytes
        next_byte = win[res.adv[1:0]];
        next_len = u8u16_pkg::lead_len(next_byte);
        res.more = (res.rest != 3'd0) && !(next_len > res.rest);
    end

endmodule
`default_nettype wire

>>> src/utf8_to_utf16_stream_decoder_top.sv
// utf-8 byte stream to utf-16 code unit decoder, top level
// depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if, u8u16_step and the macro header
//
// byte_ch takes one utf-8 byte per transaction; unit_ch gives utf-16 code units,
// with is_replacement set on each U+FFFD produced for an invalid sequence and last
// set on the final unit caused by a byte. a byte that only extends a partial
// sequence produces no unit at all.
// a byte is taken into the held bytes, then a small sequencer runs the shared decode
// unit once per cycle over the held bytes, one code unit per cycle into the
// output register while unit_ch does not stall. a byte causes from 1 to 4 units
// or none. the first unit of a byte is decoded in the decode state and then
// registered in the output register that drives unit_ch.
// byte_ch.ready is high only while the sequencer is idle; the next byte may be
// taken while the last unit still waits in the output register.
// when unit_ch stalls, the sequencer holds its step until the output register
// frees, so nothing is lost or repeated.
// reset empties the held tail and the output register. a truncated sequence is
// kept with no timeout until the bytes that complete it arrive.
`default_nettype none
`include "utf8_to_utf16_stream_decoder_top_macros.svh"
module utf8_to_utf16_stream_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    u8u16_byte_if.sink      byte_ch,
    u8u16_unit_if.source    unit_ch
);

    u8u16_pkg::state_t state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [3:0][7:0]   buf_reg, buf_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       unit_reg, unit_next;
    logic              rep_reg, rep_next;
    logic              last_reg, last_next;
    logic [15:0]       lo_reg, lo_next;
    logic              more_reg, more_next;
    logic [3:0][7:0]   shifted;
    logic              slot_free;
    logic              in_fire;
    u8u16_pkg::step_t  step;

    u8u16_step u_step (
        .win   (buf_reg),
        .count (cnt_reg),
        .res   (step)
    );

    assign slot_free = !out_valid_reg || unit_ch.ready;
    assign byte_ch.ready = (state_reg == u8u16_pkg::ST_IDLE);
    assign in_fire = byte_ch.valid && byte_ch.ready;

    assign unit_ch.valid = out_valid_reg;
    assign unit_ch.code_unit = unit_reg;
    assign unit_ch.is_replacement = rep_reg;
    assign unit_ch.last = last_reg;

    // window after dropping the consumed bytes
    always_comb
    begin
        logic [2:0] idx;
        for (int k = 0; k < 4; k++)
        begin
            idx = 3'(k) + step.adv;
            shifted[k] = (idx < 3'd4) ? buf_reg[idx[1:0]] : buf_reg[k];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        buf_next = buf_reg;
        out_valid_next = out_valid_reg && !unit_ch.ready;
        unit_next = unit_reg;
        rep_next = rep_reg;
        last_next = last_reg;
        lo_next = lo_reg;
        more_next = more_reg;
        unique case (state_reg)
            u8u16_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    buf_next[cnt_reg[1:0]] = byte_ch.byte_in;
                    cnt_next = cnt_reg + 3'd1;
                    state_next = u8u16_pkg::ST_DECODE;
                end
            end
            u8u16_pkg::ST_DECODE:
            begin
                if (step.stop)
                begin
                    state_next = u8u16_pkg::ST_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    unit_next = step.unit_hi;
                    rep_next = step.rep;
                    last_next = !step.pair && !step.more;
                    lo_next = step.unit_lo;
                    more_next = step.more;
                    buf_next = shifted;
                    cnt_next = step.rest;
                    if (step.pair)
                        state_next = u8u16_pkg::ST_LOW;
                    else if (step.more)
                        state_next = u8u16_pkg::ST_DECODE;
                    else
                        state_next = u8u16_pkg::ST_IDLE;
                end
            end
            u8u16_pkg::ST_LOW:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    unit_next = lo_reg;
                    rep_next = 1'b0;
                    last_next = !more_reg;
                    state_next = more_reg ? u8u16_pkg::ST_DECODE : u8u16_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = u8u16_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= u8u16_pkg::ST_IDLE;
            cnt_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        unit_reg <= unit_next;
        rep_reg <= rep_next;
        last_reg <= last_next;
        lo_reg <= lo_next;
        more_reg <= more_next;
    end

    `U8U16_ASSERT_IMP(a_idle_tail, clk, rst_n, state_reg == u8u16_pkg::ST_IDLE,
        cnt_reg <= 3'd3, "held tail longer than three bytes while idle")
    `U8U16_ASSERT_IMP(a_low_after_high, clk, rst_n, state_reg == u8u16_pkg::ST_LOW,
        out_valid_reg, "low surrogate pending without a high half in the output register")
    `U8U16_ASSERT_NXT(a_accept_decode, clk, rst_n, in_fire,
        state_reg == u8u16_pkg::ST_DECODE && cnt_reg != 3'd0,
        "accepted byte did not start a decode pass")
    `U8U16_ASSERT_IMP(a_not_last_pending, clk, rst_n, out_valid_reg && !last_reg,
        state_reg != u8u16_pkg::ST_IDLE, "unit without last but no further unit pending")

endmodule
`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench of the utf-8 to utf-16 stream decoder
// needs u8u16_byte_if, u8u16_unit_if and utf8_to_utf16_stream_decoder_top; predicts every unit
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam logic [15:0] REPL_CODE = 16'hFFFD;
    localparam logic [15:0] HI_HALF_BASE = 16'hD800;
    localparam logic [15:0] LO_HALF_BASE = 16'hDC00;
    localparam logic [20:0] PLANE1_BASE = 21'h10000;
    localparam logic [20:0] SCALAR_MAX = 21'h10FFFF;
    localparam int PAUSE_MARK = -1;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_STARVED
    } rx_mode_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last;
    } unit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte = 8'h00;
    logic       rcv_ready = 1'b0;

    u8u16_byte_if byte_ch ();
    u8u16_unit_if unit_ch ();

    assign byte_ch.valid = drv_valid;
    assign byte_ch.byte_in = drv_byte;
    assign unit_ch.ready = rcv_ready;

    utf8_to_utf16_stream_decoder_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .unit_ch (unit_ch)
    );

    // stimulus and expectations
    int    byte_queue[$];
    unit_t expected_units[$];

    // predictor copy of the undecoded tail
    logic [7:0] tail_bytes[3];
    int         tail_len = 0;

    int fail_cnt = 0;
    int bytes_taken = 0;
    int units_checked = 0;
    int repl_seen = 0;
    int halves_seen = 0;
    logic units_clear = 1'b1;

    // driver state
    int burst_left = 0;
    int gap_left = 0;
    logic draining = 1'b0;
    logic drain_armed = 1'b0;
    int next_item;

    // receiver state
    rx_mode_t rx_mode = RX_STEADY;
    int mode_left = 0;

    unit_t got_unit;
    unit_t want_unit;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int seq_len(input logic [7:0] b);
        int n;
        n = 0;
        if (b >= 8'hC2 && b <= 8'hDF)
            n = 2;
        else if (b >= 8'hE0 && b <= 8'hEF)
            n = 3;
        else if (b >= 8'hF0 && b <= 8'hF4)
            n = 4;
        return n;
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic void push_unit(input logic [15:0] cu, input logic rep);
        unit_t u;
        u.code_unit = cu;
        u.is_replacement = rep;
        u.last = 1'b0;
        expected_units = {expected_units, u};
    endfunction

    function automatic void queue_byte(input int b);
        byte_queue = {byte_queue, b};
    endfunction

    // append one byte to the tail and predict every unit it releases
    function automatic void decode_byte(input logic [7:0] nb);
        logic [7:0]  win[4];
        logic [7:0]  b0, b1, b2, b3;
        logic [20:0] cp;
        logic [19:0] off;
        logic        bad;
        int          n, i, k, len, first;
        first = expected_units.size();
        n = tail_len;
        for (k = 0; k < n; k++)
            win[k] = tail_bytes[k];
        win[n] = nb;
        n++;
        i = 0;
        while (i < n)
        begin
            b0 = win[i];
            len = seq_len(b0);
            if (b0 < 8'h80)
            begin
                push_unit({8'h00, b0}, 1'b0);
                i++;
            end
            else if (len == 0)
            begin
                push_unit(REPL_CODE, 1'b1);
                i++;
            end
            else if (i + len > n)
                break;
            else
            begin
                b1 = win[i + 1];
                b2 = (len > 2) ? win[i + 2] : 8'h80;
                b3 = (len > 3) ? win[i + 3] : 8'h80;
                bad = !is_trail(b1);
                if (len == 2)
                    cp = {10'd0, b0[4:0], b1[5:0]};
                else if (len == 3)
                    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                else
                    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                if (len >= 3)
                    bad = bad || !is_trail(b2) || (b0 == 8'hE0 && b1 < 8'hA0) ||
                          (b0 == 8'hED && b1 > 8'h9F);
                if (len == 4)
                    bad = bad || !is_trail(b3) || (b0 == 8'hF0 && b1 < 8'h90) ||
                          (b0 == 8'hF4 && b1 > 8'h8F) || (cp > SCALAR_MAX);
                if (bad)
                begin
                    // only the lead byte goes, the rest is scanned again
                    push_unit(REPL_CODE, 1'b1);
                    i++;
                end
                else
                begin
                    if (cp <= 21'h00FFFF)
                        push_unit(cp[15:0], 1'b0);
                    else
                    begin
                        off = 20'(cp - PLANE1_BASE);
                        push_unit(HI_HALF_BASE + {6'd0, off[19:10]}, 1'b0);
                        push_unit(LO_HALF_BASE + {6'd0, off[9:0]}, 1'b0);
                    end
                    i += len;
                end
            end
        end
        k = 0;
        while (i < n && k < 3)
        begin
            tail_bytes[k] = win[i];
            k++;
            i++;
        end
        tail_len = k;
        if (expected_units.size() > first)
            expected_units[expected_units.size() - 1].last = 1'b1;
    endfunction

    function automatic void encode_scalar(input logic [20:0] cp, output logic [7:0] enc[4],
                                          output int len);
        if (cp < 21'h80)
        begin
            len = 1;
            enc[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            len = 2;
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            len = 3;
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            len = 4;
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
        end
    endfunction

    function automatic logic [20:0] pick_scalar(input int nbytes);
        logic [20:0] cp;
        case (nbytes)
            1: cp = 21'($urandom_range(0, 16'h7F));
            2: cp = 21'($urandom_range(16'h80, 16'h7FF));
            3:
            begin
                cp = 21'($urandom_range(16'h800, 16'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h4000;  // move out of the surrogate block
            end
            default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
        // lean on the range edges now and then
        if ($urandom_range(0, 7) == 0)
        begin
            case (nbytes)
                1: cp = $urandom_range(0, 1) ? 21'h7F : 21'h00;
                2: cp = $urandom_range(0, 1) ? 21'h7FF : 21'h80;
                3: cp = $urandom_range(0, 1) ? 21'hFFFF : 21'h800;
                default: cp = $urandom_range(0, 1) ? SCALAR_MAX : PLANE1_BASE;
            endcase
        end
        return cp;
    endfunction

    // random stream: mostly well-formed text, some noise, cut and damaged sequences
    task automatic fill_random(input int count);
        logic [7:0] enc[4];
        int len, r, m, pos, start;
        start = byte_queue.size();
        while (byte_queue.size() - start < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
            begin
                m = (r < 25) ? 1 : (r < 45) ? 2 : (r < 65) ? 3 : 4;
                encode_scalar(pick_scalar(m), enc, len);
                for (int j = 0; j < len; j++)
                    queue_byte(int'(enc[j]));
            end
            else if (r < 86)
                queue_byte(int'($urandom_range(0, 255)));
            else if (r < 93)
            begin
                encode_scalar(pick_scalar($urandom_range(2, 4)), enc, len);
                m = $urandom_range(1, len - 1);
                for (int j = 0; j < m; j++)
                    queue_byte(int'(enc[j]));
            end
            else
            begin
                encode_scalar(pick_scalar($urandom_range(2, 4)), enc, len);
                pos = $urandom_range(0, len - 1);
                enc[pos] = 8'($urandom_range(0, 255));
                for (int j = 0; j < len; j++)
                    queue_byte(int'(enc[j]));
            end
        end
    endtask

    // driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            draining = 1'b0;
            drain_armed = 1'b0;
        end
        else if (!drv_valid || byte_ch.ready)
        begin
            if (draining)
            begin
                drv_valid <= 1'b0;
                // units_clear is registered, so skip the first look
                if (drain_armed && units_clear)
                begin
                    draining = 1'b0;
                    gap_left = 3;
                end
                drain_armed = 1'b1;
            end
            else if (gap_left > 0)
            begin
                drv_valid <= 1'b0;
                gap_left--;
            end
            else if (byte_queue.size() > 0)
            begin
                next_item = byte_queue.pop_front();
                if (next_item == PAUSE_MARK)
                begin
                    drv_valid <= 1'b0;
                    draining = 1'b1;
                    drain_armed = 1'b0;
                end
                else
                begin
                    drv_valid <= 1'b1;
                    drv_byte <= next_item[7:0];
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // receiver: stall pattern switches between steady, choppy and starved stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcv_ready <= 1'b0;
            mode_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (rx_mode)
                RX_STEADY: rcv_ready <= 1'b1;
                RX_CHOPPY: rcv_ready <= ($urandom_range(0, 3) != 0);
                default: rcv_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // monitor: predict on each byte transaction, check each unit transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_len = 0;
            units_clear <= 1'b1;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                decode_byte(byte_ch.byte_in);
                bytes_taken++;
            end
            if (unit_ch.valid && unit_ch.ready)
            begin
                got_unit.code_unit = unit_ch.code_unit;
                got_unit.is_replacement = unit_ch.is_replacement;
                got_unit.last = unit_ch.last;
                if (expected_units.size() == 0)
                begin
                    $error("unexpected unit: code_unit %h is_replacement %b last %b",
                           got_unit.code_unit, got_unit.is_replacement, got_unit.last);
                    fail_cnt++;
                end
                else
                begin
                    want_unit = expected_units.pop_front();
                    if (got_unit.code_unit !== want_unit.code_unit)
                    begin
                        $error("code_unit: expected %h actual %h",
                               want_unit.code_unit, got_unit.code_unit);
                        fail_cnt++;
                    end
                    if (got_unit.is_replacement !== want_unit.is_replacement)
                    begin
                        $error("is_replacement: expected %b actual %b",
                               want_unit.is_replacement, got_unit.is_replacement);
                        fail_cnt++;
                    end
                    if (got_unit.last !== want_unit.last)
                    begin
                        $error("last: expected %b actual %b", want_unit.last, got_unit.last);
                        fail_cnt++;
                    end
                    if (want_unit.is_replacement)
                        repl_seen++;
                    if (want_unit.code_unit[15:11] == 5'b11011)
                        halves_seen++;
                end
                units_checked++;
            end
            units_clear <= (expected_units.size() == 0);
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d units still expected", expected_units.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        // directed: field extremes, each sequence length, the edge checks, bad leads
        byte_queue = '{8'h00, 8'h7F, 8'hC2, 8'h80,
                       8'hEF, 8'hBF, 8'hBD,             // valid U+FFFD, not a replacement
                       8'hF4, 8'h8F, 8'hBF, 8'hBF,      // top scalar as a surrogate pair
                       8'h80, 8'hC1, 8'hF5, 8'hFF,      // bad leads
                       8'hE0, 8'h9F, 8'h80,             // overlong three-byte form
                       8'hED, 8'hA0, 8'h80,             // encoded surrogate
                       8'hF4, 8'h90, 8'h80, 8'h80,      // above the scalar limit
                       PAUSE_MARK};
        fill_random(62);
        queue_byte(PAUSE_MARK);
        fill_random(62);
        queue_byte(PAUSE_MARK);
        fill_random(62);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() > 0 || drv_valid || draining || !units_clear)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (expected_units.size() != 0)
        begin
            $error("%0d expected units never arrived", expected_units.size());
            fail_cnt++;
        end

        $display("decoded %0d bytes into %0d checked units", bytes_taken, units_checked);
        $display("%0d replacements and %0d surrogate halves among them", repl_seen, halves_seen);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
